FILE: sv/ctsg_pkg.sv
// Shared types and constants for the chirp tone sample generator.
// Holds the pipeline word layout, stage numbering and register indexes.
// No dependencies.
package ctsg_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_START_FREQ  = 3'd0;
  localparam logic [2:0] REG_END_FREQ    = 3'd1;
  localparam logic [2:0] REG_PEAK_AMP    = 3'd2;
  localparam logic [2:0] REG_SAMPLE_CNT  = 3'd3;
  localparam logic [2:0] REG_SAMPLE_RATE = 3'd4;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 17;

  // Stage numbering of the pipeline
  localparam int DIV1_STEPS = 16;  // progress quotient bits
  localparam int DIV2_STEPS = 46;  // phase numerator bits
  localparam int ST_IN      = 0;
  localparam int ST_DIV1    = ST_IN + 1;
  localparam int ST_MUL     = ST_DIV1 + DIV1_STEPS;
  localparam int ST_FRQ     = ST_MUL + 1;
  localparam int ST_NUM     = ST_FRQ + 1;
  localparam int ST_DIV2    = ST_NUM + 1;
  localparam int ST_TIX     = ST_DIV2 + DIV2_STEPS;
  localparam int ST_ROM     = ST_TIX + 1;
  localparam int ST_AMP     = ST_ROM + 1;
  localparam int ST_ENV     = ST_AMP + 1;
  localparam int ST_OUT     = ST_ENV + 1;
  localparam int N_STAGES   = ST_OUT + 1;

  // ceil(2^23 / 9): exact floor(x / 9) for x below 2^21
  localparam logic [19:0] DIV9_MUL   = 20'd932068;
  localparam int          DIV9_SHIFT = 23;

  // Quarter-wave table generation, Q30
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint ONE_Q30     = 64'sd1073741824;

  typedef struct packed {
    logic        [15:0] idx;
    logic               rng;
    logic        [15:0] p;
    logic        [15:0] rem1;
    logic signed [31:0] dprod;
    logic        [19:0] ex;
    logic        [19:0] p10;
    logic        [39:0] emul;
    logic        [21:0] freq;
    logic        [15:0] env;
    logic        [45:0] num;
    logic        [16:0] rem2;
    logic        [15:0] ph;
    logic               neg;
    logic        [29:0] am;
    logic        [45:0] ae;
    logic        [15:0] sval;
  } ctsg_pl_t;

endpackage

FILE: sv/chirp_tone_sample_generator.sv
// Linear chirp sample generator with attack/decay envelope, fully pipelined.
// Depends on ctsg_pkg for the pipeline word, stage numbering and register indexes.
// Turns each sample index into one signed 16-bit sample of a linear chirp.
// One word is taken every cycle while the skid word is empty. The index
// enters the first of 71 pipeline stages at the accepting edge and the
// output register follows the last stage. The depth is set by two
// restoring dividers, one quotient bit per stage: 16 stages for the
// sweep progress (index over sample count) and 46 stages for the phase
// (frequency times index over sample rate). The output register is backed by
// a skid word, so input is still taken while one result waits to be collected.
// Configuration writes are always accepted and must only be made while no
// sample is in flight.
module chirp_tone_sample_generator
  import ctsg_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   idx_valid,
  output logic                   idx_ready,
  input  logic [15:0]            sample_index,
  output logic                   res_valid,
  input  logic                   res_ready,
  output logic signed [15:0]     sample_value,
  output logic                   in_range
);

  localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int KW = 14 + IW;

  // Quarter-wave entry n, unsigned Q0.15, by a Q30 Taylor series
  function automatic logic [14:0] sine_entry(input int n);
    longint x;
    longint term;
    longint t2;
    longint sum;
    longint v;
    x = (HALF_PI_Q30 * longint'(n)) / SINE_TABLE_DEPTH;
    term = x;
    sum = x;
    for (int k = 1; k <= 9; k++) begin
      t2 = term * x / ONE_Q30;
      t2 = t2 * x / ONE_Q30;
      case (k)
        1: term = -t2 / 64'sd6;
        2: term = -t2 / 64'sd20;
        3: term = -t2 / 64'sd42;
        4: term = -t2 / 64'sd72;
        5: term = -t2 / 64'sd110;
        6: term = -t2 / 64'sd156;
        7: term = -t2 / 64'sd210;
        8: term = -t2 / 64'sd272;
        default: term = -t2 / 64'sd342;
      endcase
      sum = sum + term;
    end
    if (sum < 0) sum = 0;
    v = (sum * 64'sd32767 + ONE_Q30 / 2) / ONE_Q30;
    if (v > 32767) v = 32767;
    return v[14:0];
  endfunction

  // Configuration registers
  logic [13:0] start_frequency;
  logic [13:0] end_frequency;
  logic [14:0] peak_amplitude;
  logic [15:0] sample_count;
  logic [16:0] sample_rate;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_frequency <= 14'd150;
      end_frequency   <= 14'd50;
      peak_amplitude  <= 15'd20000;
      sample_count    <= 16'd6615;
      sample_rate     <= 17'd22050;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_START_FREQ:  start_frequency <= cfg_data[13:0];
        REG_END_FREQ:    end_frequency   <= cfg_data[13:0];
        REG_PEAK_AMP:    peak_amplitude  <= cfg_data[14:0];
        REG_SAMPLE_CNT:  sample_count    <= cfg_data[15:0];
        REG_SAMPLE_RATE: sample_rate     <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // Pipeline
  ctsg_pl_t              pipe [N_STAGES];
  ctsg_pl_t              pipe_next [N_STAGES];
  logic [N_STAGES-1:0]   vld;
  logic                  adv;
  logic                  skid_vld;
  logic [IW-1:0]         tidx;
  logic [IW-1:0]         tidx_next;
  logic [14:0]           rom_q;
  logic [14:0]           sine_rom [SINE_TABLE_DEPTH+1];

  assign adv       = !skid_vld;
  assign idx_ready = adv;

  for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
    assign sine_rom[g] = sine_entry(g);
  end

  always_comb begin
    pipe_next[ST_IN]      = '0;
    pipe_next[ST_IN].idx  = sample_index;
    pipe_next[ST_IN].rng  = sample_index < sample_count;
    pipe_next[ST_IN].rem1 = sample_index;
  end

  for (genvar s = 1; s < N_STAGES; s++) begin : g_st
    if (s >= ST_DIV1 && s < ST_MUL) begin : g_div1
      // One quotient bit of index * 2^16 / count
      logic [16:0] r;
      logic [16:0] rd;
      logic        ge;
      always_comb begin
        r  = {pipe[s-1].rem1, 1'b0};
        rd = r - {1'b0, sample_count};
        ge = r >= {1'b0, sample_count};
        pipe_next[s]      = pipe[s-1];
        pipe_next[s].rem1 = ge ? rd[15:0] : r[15:0];
        pipe_next[s].p    = {pipe[s-1].p[14:0], ge};
      end
    end else if (s == ST_MUL) begin : g_mul
      logic signed [14:0] dfreq;
      logic        [19:0] em;
      logic        [19:0] p20;
      always_comb begin
        dfreq = $signed({1'b0, end_frequency}) - $signed({1'b0, start_frequency});
        em    = 20'(17'h10000 - {1'b0, pipe[s-1].p});
        p20   = {4'b0, pipe[s-1].p};
        pipe_next[s]       = pipe[s-1];
        pipe_next[s].dprod = 32'(dfreq) * 32'($signed({1'b0, pipe[s-1].p}));
        pipe_next[s].ex    = (em << 3) + (em << 1);
        pipe_next[s].p10   = (p20 << 3) + (p20 << 1);
      end
    end else if (s == ST_FRQ) begin : g_frq
      logic signed [31:0] dq;
      logic signed [31:0] fsum;
      always_comb begin
        // Truncate the sweep offset towards zero
        dq = pipe[s-1].dprod[31] ? ((pipe[s-1].dprod + 32'sd255) >>> 8)
                                 : (pipe[s-1].dprod >>> 8);
        fsum = $signed({10'b0, start_frequency, 8'b0}) + dq;
        pipe_next[s]      = pipe[s-1];
        pipe_next[s].freq = fsum[21:0];
        pipe_next[s].emul = 40'(pipe[s-1].ex) * 40'(DIV9_MUL);
      end
    end else if (s == ST_NUM) begin : g_num
      logic [37:0] fi;
      always_comb begin
        fi = 38'(pipe[s-1].freq) * 38'(pipe[s-1].idx);
        pipe_next[s]      = pipe[s-1];
        pipe_next[s].num  = {fi, 8'b0};
        pipe_next[s].rem2 = '0;
        pipe_next[s].ph   = '0;
        pipe_next[s].env  = (pipe[s-1].p10 < 20'h10000) ? pipe[s-1].p10[15:0]
                          : pipe[s-1].emul[DIV9_SHIFT+15:DIV9_SHIFT];
      end
    end else if (s >= ST_DIV2 && s < ST_TIX) begin : g_div2
      // One quotient bit of the phase; only the low 16 bits are kept
      logic [17:0] r;
      logic [17:0] rd;
      logic        ge;
      always_comb begin
        r  = {pipe[s-1].rem2, pipe[s-1].num[45]};
        rd = r - {1'b0, sample_rate};
        ge = r >= {1'b0, sample_rate};
        pipe_next[s]      = pipe[s-1];
        pipe_next[s].rem2 = ge ? rd[16:0] : r[16:0];
        pipe_next[s].num  = {pipe[s-1].num[44:0], 1'b0};
        pipe_next[s].ph   = {pipe[s-1].ph[14:0], ge};
      end
    end else if (s == ST_TIX) begin : g_tix
      logic [15:0]   phase;
      logic [KW-1:0] kp;
      logic [IW-1:0] k;
      always_comb begin
        // A zero sample rate gives zero phase
        phase = (sample_rate == '0) ? '0 : pipe[s-1].ph;
        kp    = KW'(phase[13:0]) * KW'(SINE_TABLE_DEPTH);
        k     = kp[KW-1:14];
        tidx_next = phase[14] ? (IW'(SINE_TABLE_DEPTH) - k) : k;
        pipe_next[s]     = pipe[s-1];
        pipe_next[s].neg = phase[15];
      end
    end else if (s == ST_AMP) begin : g_amp
      always_comb begin
        pipe_next[s]    = pipe[s-1];
        pipe_next[s].am = 30'(peak_amplitude) * 30'(rom_q);
      end
    end else if (s == ST_ENV) begin : g_env
      always_comb begin
        pipe_next[s]    = pipe[s-1];
        pipe_next[s].ae = 46'(pipe[s-1].am) * 46'(pipe[s-1].env);
      end
    end else if (s == ST_OUT) begin : g_out
      // Magnitude stays below 32766, so no clamp is reached
      logic [15:0] mag;
      always_comb begin
        mag = {1'b0, pipe[s-1].ae[45:31]};
        pipe_next[s]      = pipe[s-1];
        pipe_next[s].sval = !pipe[s-1].rng ? '0 : (pipe[s-1].neg ? -mag : mag);
      end
    end else begin : g_copy
      always_comb pipe_next[s] = pipe[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[N_STAGES-2:0], idx_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < N_STAGES; s++) pipe[s] <= pipe_next[s];
      tidx  <= tidx_next;
      rom_q <= sine_rom[tidx];
    end
  end

  // Output register and skid word
  logic [15:0] out_val;
  logic        out_rng;
  logic [15:0] skid_val;
  logic        skid_rng;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      skid_vld  <= 1'b0;
    end else if (skid_vld) begin
      if (res_ready) skid_vld <= 1'b0;
    end else if (vld[N_STAGES-1]) begin
      if (!res_valid || res_ready) res_valid <= 1'b1;
      else skid_vld <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld) begin
      if (res_ready) begin
        out_val <= skid_val;
        out_rng <= skid_rng;
      end
    end else if (vld[N_STAGES-1]) begin
      if (!res_valid || res_ready) begin
        out_val <= pipe[N_STAGES-1].sval;
        out_rng <= pipe[N_STAGES-1].rng;
      end else begin
        skid_val <= pipe[N_STAGES-1].sval;
        skid_rng <= pipe[N_STAGES-1].rng;
      end
    end
  end

  assign sample_value = $signed(out_val);
  assign in_range     = out_rng;

endmodule

FILE: test/tb.sv
// Testbench for chirp_tone_sample_generator: directed and random sample indices
// against a built-in fixed-point chirp predictor, with random stalls on both channels.
// Depends on ctsg_pkg and the chirp_tone_sample_generator RTL.
module tb
  import ctsg_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     TBL_DEPTH     = 256;
  localparam int     PIPE_LATENCY  = 71;
  localparam int     QUIET_LIMIT   = 2000;
  localparam longint QUARTER_Q30   = 64'sd1686629713;
  localparam longint UNIT_Q30      = 64'sd1073741824;
  localparam longint UNIT_Q31      = 64'sd2147483648;
  // indexes past the register list: writes there must change nothing
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LAST  = 3'd7;

  typedef struct {
    logic [15:0]        idx;
    logic signed [15:0] value;
    logic               rng;
  } chirp_sample_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   idx_valid;
  logic                   idx_ready;
  logic [15:0]            sample_index;
  logic                   res_valid;
  logic                   res_ready;
  logic signed [15:0]     sample_value;
  logic                   in_range;

  // predictor's copy of the registers
  logic [13:0] f_start   = 14'd150;
  logic [13:0] f_end     = 14'd50;
  logic [14:0] amp       = 15'd20000;
  logic [15:0] n_samples = 16'd6615;
  logic [16:0] rate      = 17'd22050;

  int            quarter_wave [0:TBL_DEPTH];
  chirp_sample_t pending_samples [$];
  int            errors  = 0;
  bit            idle_on = 1'b1;
  bit            idx_up  = 1'b0;
  bit            cfg_up  = 1'b0;

  chirp_tone_sample_generator #(.SINE_TABLE_DEPTH(TBL_DEPTH)) uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .idx_valid    (idx_valid),
    .idx_ready    (idx_ready),
    .sample_index (sample_index),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .sample_value (sample_value),
    .in_range     (in_range)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Quarter-wave entry n, Q1.15, from a Q30 Taylor series
  function automatic int quarter_wave_entry(input longint n);
    longint x, term, total, v;
    x = QUARTER_Q30 * n / TBL_DEPTH;
    term = x;
    total = x;
    for (longint k = 1; k <= 9; k++) begin
      term = term * x / UNIT_Q30;
      term = term * x / UNIT_Q30;
      term = -term / ((2 * k) * (2 * k + 1));
      total += term;
    end
    if (total < 0) total = 0;
    v = (total * 32767 + UNIT_Q30 / 2) / UNIT_Q30;
    if (v > 32767) v = 32767;
    return int'(v);
  endfunction

  function automatic chirp_sample_t chirp_sample(input logic [15:0] idx);
    chirp_sample_t r;
    longint i, cnt, prog, fq, ph, env, k, prod;
    int     sn;
    r.idx = idx;
    r.value = '0;
    r.rng = 1'b0;
    i = longint'(idx);
    cnt = longint'(n_samples);
    if (i >= cnt) return r;
    prog = (i << 16) / cnt;
    fq = longint'(f_start) * 256
       + ((longint'(f_end) - longint'(f_start)) * prog) / 256;
    if (rate == '0) ph = 0;
    else ph = ((fq * i * 256) / longint'(rate)) % 65536;
    if (prog * 10 < 65536) env = prog * 10;
    else env = ((65536 - prog) * 10) / 9;
    k = (longint'(ph[13:0]) * TBL_DEPTH) >> 14;
    sn = ph[14] ? quarter_wave[TBL_DEPTH - k] : quarter_wave[k];
    if (ph[15]) sn = -sn;
    prod = longint'(amp) * longint'(sn) * env / UNIT_Q31;
    if (prod > 32767) prod = 32767;
    if (prod < -32768) prod = -32768;
    r.value = prod[15:0];
    r.rng = 1'b1;
    return r;
  endfunction

  // Drop valid and wait until every sample in flight has been collected
  task automatic settle();
    if (idx_up) begin
      idx_valid <= 1'b0;
      idx_up = 1'b0;
    end
    while (pending_samples.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] reg_sel,
                           input logic [CFG_DATA_W-1:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_up = 1'b1;
    cfg_index <= reg_sel;
    cfg_data <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (reg_sel)
      REG_START_FREQ:  f_start = value[13:0];
      REG_END_FREQ:    f_end = value[13:0];
      REG_PEAK_AMP:    amp = value[14:0];
      REG_SAMPLE_CNT:  n_samples = value[15:0];
      REG_SAMPLE_RATE: rate = value[16:0];
      default: ;
    endcase
  endtask

  task automatic set_sweep(input logic [CFG_DATA_W-1:0] start_hz, end_hz, peak, cnt, sr);
    write_reg(REG_START_FREQ, start_hz);
    write_reg(REG_END_FREQ, end_hz);
    write_reg(REG_PEAK_AMP, peak);
    write_reg(REG_SAMPLE_CNT, cnt);
    write_reg(REG_SAMPLE_RATE, sr);
  endtask

  task automatic send_index(input logic [15:0] idx);
    int gap;
    if (cfg_up) begin
      cfg_valid <= 1'b0;
      cfg_up = 1'b0;
    end
    if (idle_on && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 13);
      if (idx_up) begin
        idx_valid <= 1'b0;
        idx_up = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    idx_valid <= 1'b1;
    idx_up = 1'b1;
    sample_index <= idx;
    do @(posedge clk); while (idx_ready !== 1'b1);
    pending_samples.insert(pending_samples.size(), chirp_sample(idx));
  endtask

  task automatic send_random_indices(input int count);
    logic [15:0] idx;
    repeat (count) begin
      if (n_samples != '0 && $urandom_range(0, 99) < 85)
        idx = 16'($urandom_range(0, n_samples - 1));
      else
        idx = 16'($urandom_range(0, 16'hFFFF));
      send_index(idx);
    end
  endtask

  task automatic test_reset_defaults();
    logic [15:0] picks [8] = '{16'd0, 16'd1, 16'd661, 16'd662, 16'd3307, 16'd6614,
                               16'd6615, 16'hFFFF};
    foreach (picks[n]) send_index(picks[n]);
  endtask

  task automatic test_register_extremes();
    // above-range start, steepest downward sweep, widest count, slowest rate
    set_sweep(17'd16383, 17'd1, 17'd32767, 17'd65535, 17'd1000);
    send_index(16'd0);
    send_index(16'd6553);
    send_index(16'd6554);
    send_index(16'd32768);
    send_index(16'd65534);
    send_index(16'hFFFF);
    // one-sample sweep, silent amplitude
    set_sweep(17'd1, 17'd11025, 17'd0, 17'd1, 17'd96000);
    send_index(16'd0);
    send_index(16'd1);
    // every data bit set on the rate register
    set_sweep(17'd11025, 17'd11025, 17'd32767, 17'd100, 17'h1FFFF);
    send_index(16'd37);
    for (int r = REG_SPARE_FIRST; r <= REG_SPARE_LAST; r++)
      write_reg(CFG_INDEX_W'(r), 17'h1FFFF);
    send_index(16'd63);
    // zero rate holds the phase at zero
    set_sweep(17'd440, 17'd880, 17'd32767, 17'd100, 17'd0);
    send_index(16'd50);
    // zero count leaves every index out of range
    write_reg(REG_SAMPLE_CNT, 17'd0);
    send_index(16'd0);
    send_index(16'hFFFF);
  endtask

  task automatic test_random_sweeps();
    for (int ph = 0; ph < 8; ph++) begin
      if (ph % 2 == 1) begin
        set_sweep(17'($urandom_range(0, 17'h1FFFF)), 17'($urandom_range(0, 17'h1FFFF)),
                  17'($urandom_range(0, 17'h1FFFF)), 17'($urandom_range(0, 17'h1FFFF)),
                  17'($urandom_range(0, 17'h1FFFF)));
        write_reg(CFG_INDEX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                  17'($urandom_range(0, 17'h1FFFF)));
      end else begin
        set_sweep(17'($urandom_range(1, 11025)), 17'($urandom_range(1, 11025)),
                  17'($urandom_range(0, 32767)),
                  17'($urandom_range(0, 1) ? $urandom_range(1, 400) : $urandom_range(1, 65535)),
                  17'($urandom_range(1000, 96000)));
      end
      send_random_indices(90);
    end
  endtask

  task automatic test_full_rate();
    settle();
    idle_on = 1'b0;
    set_sweep(17'd150, 17'd50, 17'd20000, 17'($urandom_range(200, 65535)), 17'd22050);
    send_random_indices(160);
  endtask

  initial begin : stimulus
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    idx_valid <= 1'b0;
    sample_index <= '0;
    for (int n = 0; n <= TBL_DEPTH; n++) quarter_wave[n] = quarter_wave_entry(n);
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_register_extremes();
    test_random_sweeps();
    test_full_rate();
    settle();
    repeat (PIPE_LATENCY + 16) @(posedge clk);
    if (pending_samples.size() != 0) begin
      $error("%0d expected samples never arrived", pending_samples.size());
      errors += pending_samples.size();
    end
    if (errors == 0)
      $display("chirp_tone_sample_generator verification clean");
    else
      $display("chirp_tone_sample_generator verification failed");
    $finish;
  end

  initial begin : result_checker
    chirp_sample_t want;
    int hold;
    hold = 0;
    res_ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      @(posedge clk);
      if (res_valid === 1'b1 && res_ready === 1'b1) begin
        if (pending_samples.size() == 0) begin
          $error("unexpected word: sample_value %0d in_range %0b", sample_value, in_range);
          errors++;
        end else begin
          want = pending_samples.pop_front();
          if (sample_value !== want.value) begin
            $error("index %0d sample_value: expected %0d, got %0d",
                   want.idx, want.value, sample_value);
            errors++;
          end
          if (in_range !== want.rng) begin
            $error("index %0d in_range: expected %0b, got %0b", want.idx, want.rng, in_range);
            errors++;
          end
        end
      end
      if (hold > 0) begin
        hold--;
        res_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
        hold = $urandom_range(1, 13) - 1;
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((idx_valid && idx_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("chirp_tone_sample_generator verification failed");
    $finish;
  end

endmodule
